>>> sv/avcc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avcc_pkg
// Types and constants shared by the length-prefixed payload validator.
// ----------------------------------------------------------------------------
package avcc_pkg;

   localparam int unsigned LengthWidth = 32;
   localparam int unsigned AccumWidth  = 24;

   localparam logic [LengthWidth-1:0] LIMIT_RESET = 32'd2097152;
   localparam logic [2:0]             MIN_PAYLOAD = 3'd5;
   localparam logic [7:0]             TYPE_MASK   = 8'h1F;
   localparam logic [7:0]             TYPE_SLICE  = 8'd1;
   localparam logic [7:0]             TYPE_IDR    = 8'd5;
   localparam logic [1:0]             LAST_LENGTH_BYTE = 2'd3;

   typedef enum logic [2:0] {
      REASON_OK       = 3'd0,
      REASON_SHORT    = 3'd1,
      REASON_ZERO_LEN = 3'd2,
      REASON_OVER     = 3'd3,
      REASON_TRUNC    = 3'd4,
      REASON_PARTIAL  = 3'd5,
      REASON_NO_PIC   = 3'd6
   } reason_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_item_type;

   typedef struct packed {
      logic       valid_res;
      logic [2:0] fail_reason;
   } rsp_item_type;

endpackage

>>> sv/avcc_payload_validator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avcc_payload_validator
// Byte-serial checker for length-prefixed video payloads.
// ----------------------------------------------------------------------------
// The block takes one payload byte per cycle, with last_byte set on the final
// byte, and gives exactly one verdict per payload on the result channel. A
// payload is a run of units, each a 4-byte big-endian length and then that
// many body bytes; the verdict reports the failure with the lowest code as
// fail_reason (0 ok, 1 under 5 bytes, 2 zero length, 3 length above
// max_unit_length, 4 truncated unit, 5 partial length, 6 no picture unit) and
// sets valid_res only for a clean payload. Throughput is one byte per cycle
// while no verdict is stalled: the only loop is the per-byte update of the
// parse state, a 32-bit decrement and a 32-bit compare against the limit. A
// byte waits in the input register and is parsed as it leaves it, and at that
// same edge the verdict for a last byte is loaded into the result register.
// Bytes other than the last one never wait on the result channel; a last byte
// waits in the input register only while a previous verdict is still stalled
// there.
// ----------------------------------------------------------------------------
module avcc_payload_validator (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  avcc_pkg::req_item_type            req_payload,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output avcc_pkg::rsp_item_type            rsp_payload,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [avcc_pkg::LengthWidth-1:0]  csr_data
);
   import avcc_pkg::*;

   // Limit register; the user must issue writes only while the block is idle, as the block does not enforce this.
   logic [LengthWidth-1:0] limit_ff;

   // Input register holding the byte about to be parsed.
   logic         in_valid_ff, in_valid_in;
   req_item_type in_item_ff;

   logic       advance;
   logic       accept;
   logic       rsp_room;
   reason_type reason;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else if (csr_valid) begin
         limit_ff <= csr_data;
      end
   end

   // A byte moves on unless it carries a verdict and the result register is
   // holding an earlier one that is still stalled.
   assign advance   = in_valid_ff && (!in_item_ff.last_byte || rsp_room);
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_item_ff <= req_payload;
      end
   end

   avcc_parser u_parser (
      .clock           (clock),
      .reset           (reset),
      .step            (advance),
      .item            (in_item_ff),
      .max_unit_length (limit_ff),
      .reason          (reason)
   );

   avcc_rsp_stage u_rsp (
      .clock       (clock),
      .reset       (reset),
      .load        (advance && in_item_ff.last_byte),
      .reason      (reason),
      .room        (rsp_room),
      .rsp_stall   (rsp_stall),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

   // Only a last byte can be held back, and only behind a stalled verdict.
   a_hold_cause : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_item_ff.last_byte && rsp_valid && rsp_stall))
      else $error("input held without a stalled verdict ahead of it");

endmodule

>>> sv/avcc_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avcc_parser
// Per-payload parse state and the verdict for the byte being retired.
// ----------------------------------------------------------------------------
module avcc_parser (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step,
   input  avcc_pkg::req_item_type        item,
   input  logic [avcc_pkg::LengthWidth-1:0] max_unit_length,
   output avcc_pkg::reason_type          reason
);
   import avcc_pkg::*;

   logic [2:0]             count_ff,     count_in;
   logic                   in_body_ff,   in_body_in;
   logic [1:0]             index_ff,     index_in;
   logic [AccumWidth-1:0]  accum_ff,     accum_in;
   logic [LengthWidth-1:0] remain_ff,    remain_in;
   logic                   header_ff,    header_in;
   logic                   picture_ff,   picture_in;
   reason_type             error_ff,     error_in;

   logic [LengthWidth-1:0] length_full;
   logic [LengthWidth-1:0] remain_dec;
   logic [7:0]             unit_type;

   assign length_full = {accum_ff, item.data_byte};
   assign remain_dec  = remain_ff - 32'd1;
   assign unit_type   = item.data_byte & TYPE_MASK;

   // State after this byte, before any end-of-payload clear.
   always_comb begin
      count_in   = (count_ff < MIN_PAYLOAD) ? count_ff + 3'd1 : count_ff;
      in_body_in = in_body_ff;
      index_in   = index_ff;
      accum_in   = accum_ff;
      remain_in  = remain_ff;
      header_in  = header_ff;
      picture_in = picture_ff;
      error_in   = error_ff;
      if (error_ff == REASON_OK) begin
         if (!in_body_ff) begin
            if (index_ff != LAST_LENGTH_BYTE) begin
               index_in = index_ff + 2'd1;
               accum_in = length_full[AccumWidth-1:0];
            end else begin
               index_in = 2'd0;
               accum_in = '0;
               if (length_full == '0) begin
                  error_in = REASON_ZERO_LEN;
               end else if (length_full > max_unit_length) begin
                  error_in = REASON_OVER;
               end else begin
                  in_body_in = 1'b1;
                  remain_in  = length_full;
                  header_in  = 1'b1;
               end
            end
         end else begin
            if (header_ff) begin
               if (unit_type == TYPE_SLICE || unit_type == TYPE_IDR) begin
                  picture_in = 1'b1;
               end
               header_in = 1'b0;
            end
            remain_in = remain_dec;
            if (remain_dec == '0) begin
               in_body_in = 1'b0;
            end
         end
      end
   end

   // Verdict follows the order of the checks: first match wins.
   always_comb begin
      if (count_in < MIN_PAYLOAD) begin
         reason = REASON_SHORT;
      end else if (error_in != REASON_OK) begin
         reason = error_in;
      end else if (in_body_in) begin
         reason = REASON_TRUNC;
      end else if (index_in != 2'd0) begin
         reason = REASON_PARTIAL;
      end else if (!picture_in) begin
         reason = REASON_NO_PIC;
      end else begin
         reason = REASON_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (step && item.last_byte)) begin
         count_ff   <= '0;
         in_body_ff <= 1'b0;
         index_ff   <= '0;
         accum_ff   <= '0;
         remain_ff  <= '0;
         header_ff  <= 1'b0;
         picture_ff <= 1'b0;
         error_ff   <= REASON_OK;
      end else if (step) begin
         count_ff   <= count_in;
         in_body_ff <= in_body_in;
         index_ff   <= index_in;
         accum_ff   <= accum_in;
         remain_ff  <= remain_in;
         header_ff  <= header_in;
         picture_ff <= picture_in;
         error_ff   <= error_in;
      end
   end

   a_error_codes : assert property (@(posedge clock) disable iff (reset)
      error_ff == REASON_OK || error_ff == REASON_ZERO_LEN || error_ff == REASON_OVER)
      else $error("latched error is not a length error");

   a_body_clean : assert property (@(posedge clock) disable iff (reset)
      in_body_ff |-> (index_ff == 2'd0 && accum_ff == '0))
      else $error("length gather state left over inside a unit body");

   a_remain_body : assert property (@(posedge clock) disable iff (reset)
      (remain_ff != '0) == in_body_ff)
      else $error("body count disagrees with body flag");

endmodule

>>> sv/avcc_rsp_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avcc_rsp_stage
// Result register that holds a verdict until the downstream side takes it.
// ----------------------------------------------------------------------------
module avcc_rsp_stage (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  avcc_pkg::reason_type   reason,
   output logic                   room,
   input  logic                   rsp_stall,
   output logic                   rsp_valid,
   output avcc_pkg::rsp_item_type rsp_payload
);
   import avcc_pkg::*;

   logic         valid_ff, valid_in;
   rsp_item_type item_ff,  item_in;

   // The register can take a new verdict when empty or when its transfer completes.
   assign room = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
      item_in.valid_res   = (reason == REASON_OK);
      item_in.fail_reason = reason;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= item_in;
      end
   end

   assign rsp_valid   = valid_ff;
   assign rsp_payload = item_ff;

endmodule
